/* hw/rtl/plpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plpd_pkg
// shared types and constants of the polyline point-at-distance unit
// ----------------------------------------------------------------------------
package plpd_pkg;

    localparam int COORD_W = 32;
    localparam int DIST_W  = 40;
    localparam int LEN_W   = 33;
    localparam int RAD_W   = 65;
    localparam int NUM_W   = 66;

    typedef logic [1:0]         t_action;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [DIST_W-1:0]  t_dist;
    typedef logic [LEN_W-1:0]   t_len;

    localparam t_action ACT_APPEND = 2'd0;
    localparam t_action ACT_CLEAR  = 2'd1;
    localparam t_action ACT_POINT  = 2'd2;
    localparam t_action ACT_LENGTH = 2'd3;

endpackage

/* hw/rtl/plpd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plpd_cmd_if / plpd_res_if
// valid/ready channels carrying commands and results
// ----------------------------------------------------------------------------
interface plpd_cmd_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               action;
    logic signed [31:0]       pos_x;
    logic signed [31:0]       pos_y;
    logic [39:0]              distance;
    modport source (output valid, action, pos_x, pos_y, distance, input ready);
    modport sink   (input valid, action, pos_x, pos_y, distance, output ready);
endinterface

interface plpd_res_if;
    logic                     valid;
    logic                     ready;
    logic signed [31:0]       result_x;
    logic signed [31:0]       result_y;
    logic [39:0]              path_length;
    logic                     rejected;
    modport source (output valid, result_x, result_y, path_length, rejected,
                    input ready);
    modport sink   (input valid, result_x, result_y, path_length, rejected,
                    output ready);
endinterface

/* hw/rtl/plpd_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plpd_isqrt
// bit-serial square root, two radicand bits per cycle, rounded to nearest
// ----------------------------------------------------------------------------
module plpd_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [plpd_pkg::RAD_W-1:0] i_rad,
    output logic                       o_done,
    output logic [plpd_pkg::LEN_W-1:0] o_root
);
    import plpd_pkg::*;

    logic [RAD_W:0]   r_rad;
    logic [35:0]      r_rem;
    logic [LEN_W-1:0] r_root;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [35:0]      rem_sh;
    logic [35:0]      trial;
    logic             ge;

    assign rem_sh = {r_rem[33:0], r_rad[RAD_W:RAD_W-1]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(LEN_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= {1'b0, i_rad};
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-2:0], 2'b00};
            r_rem  <= ge ? rem_sh - trial : rem_sh;
            r_root <= {r_root[LEN_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root + LEN_W'(r_rem > {3'b000, r_root});

endmodule

/* hw/rtl/plpd_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plpd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module plpd_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [plpd_pkg::NUM_W-1:0]   i_num,
    input  logic [plpd_pkg::LEN_W-1:0]   i_den,
    output logic                         o_done,
    output logic [plpd_pkg::COORD_W-1:0] o_quo
);
    import plpd_pkg::*;

    logic [NUM_W-1:0] r_num;
    logic [LEN_W-1:0] r_den;
    logic [LEN_W-1:0] r_rem;
    logic [6:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [LEN_W:0]   rem_sh;
    logic             ge;

    assign rem_sh = {r_rem, r_num[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? LEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[LEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num[COORD_W-1:0];

endmodule

/* hw/rtl/polyline_point_at_distance_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_point_at_distance_unit
// polyline store with path length and point-at-distance queries
// ----------------------------------------------------------------------------
// One command at a time. Append and clear go straight to the result. A length
// query reads every stored waypoint, each costing the 33-step square root of
// its leg. A point query costs the same for every leg walked, plus the two
// 66-step divisions of the interpolated leg. The waypoints live in a memory
// with one write port and one read port, read one entry per leg.
// ----------------------------------------------------------------------------
module polyline_point_at_distance_unit #(
    parameter int MAX_WAYPOINTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    plpd_cmd_if.sink    i_cmd,
    plpd_res_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import plpd_pkg::*;

    localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_LEG  = 4'd2;
    localparam logic [3:0] S_SQX  = 4'd3;
    localparam logic [3:0] S_SQY  = 4'd4;
    localparam logic [3:0] S_SUM  = 4'd5;
    localparam logic [3:0] S_SQS  = 4'd6;
    localparam logic [3:0] S_SQW  = 4'd7;
    localparam logic [3:0] S_LEN  = 4'd8;
    localparam logic [3:0] S_MUL  = 4'd9;
    localparam logic [3:0] S_NUM  = 4'd10;
    localparam logic [3:0] S_DVS  = 4'd11;
    localparam logic [3:0] S_DVW  = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    logic [3:0]         r_state;
    t_action            r_act;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    t_coord             r_start_x;
    t_coord             r_start_y;
    t_coord             r_px;
    t_coord             r_py;
    t_coord             r_wx;
    t_coord             r_wy;
    t_coord             r_ax;
    t_coord             r_ay;
    logic               r_sx;
    logic               r_sy;
    t_dist              r_dist;
    t_dist              r_total;
    t_len               r_len;
    logic [RAD_W-1:0]   r_sum;
    logic [63:0]        r_prod;
    logic [NUM_W-1:0]   r_num;
    logic               r_axis;
    logic [63:0]        r_rdata;
    logic [63:0]        mem [MAX_WAYPOINTS];
    t_coord             r_rx;
    t_coord             r_ry;
    t_dist              r_plen;
    logic               r_rej;
    logic               r_ovalid;
    t_coord             r_ox;
    t_coord             r_oy;
    t_dist              r_olen;
    logic               r_orej;

    logic               cmd_fire;
    logic               mem_we;
    t_coord             m_a;
    t_coord             m_b;
    logic [32:0]        dx;
    logic [32:0]        dy;
    logic               sq_done;
    t_len               sq_root;
    logic               dv_done;
    t_coord             dv_quo;
    logic [DIST_W:0]    tot_sum;
    t_dist              tot_sat;
    t_dist              dist_left;
    logic               last_leg;
    t_coord             mag;
    t_coord             base;
    t_coord             interp;

    // configuration port
    assign pready = 1'b1;
    assign prdata = paddr[2] ? r_start_y : r_start_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) begin
                r_start_y <= pwdata;
            end else begin
                r_start_x <= pwdata;
            end
        end
    end

    // waypoint memory
    assign cmd_fire = i_cmd.valid && i_cmd.ready;
    assign mem_we   = cmd_fire && (i_cmd.action == ACT_APPEND)
                      && (r_count < CW'(MAX_WAYPOINTS));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[AW-1:0]] <= {i_cmd.pos_x, i_cmd.pos_y};
        end
        r_rdata <= mem[r_idx[AW-1:0]];
    end

    // shared multiplier
    always_comb begin
        m_a = r_ax;
        m_b = r_ax;
        unique case (r_state)
            S_SQY: begin
                m_a = r_ay;
                m_b = r_ay;
            end
            S_MUL: begin
                m_a = r_axis ? r_ay : r_ax;
                m_b = r_dist[31:0];
            end
            default: begin
                m_a = r_ax;
                m_b = r_ax;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(m_a) * 64'(m_b);
    end

    assign dx = {r_rdata[63], r_rdata[63:32]} - {r_px[31], r_px};
    assign dy = {r_rdata[31], r_rdata[31:0]} - {r_py[31], r_py};

    plpd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SQS),
        .i_rad   (r_sum),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    plpd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DVS),
        .i_num   (r_num),
        .i_den   (r_len),
        .o_done  (dv_done),
        .o_quo   (dv_quo)
    );

    assign tot_sum   = {1'b0, r_total} + (DIST_W + 1)'(r_len);
    assign tot_sat   = tot_sum[DIST_W] ? {DIST_W{1'b1}} : tot_sum[DIST_W-1:0];
    assign dist_left = r_dist - DIST_W'(r_len);
    assign last_leg  = (r_idx + CW'(1)) == r_count;
    assign mag       = r_axis ? r_ay : r_ax;
    assign base      = r_axis ? r_py : r_px;
    assign interp    = (r_axis ? r_sy : r_sx) ? base - dv_quo : base + dv_quo;

    assign i_cmd.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_ovalid || o_res.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (cmd_fire) begin
                        r_act   <= i_cmd.action;
                        r_rx    <= (i_cmd.action == ACT_POINT) ? r_start_x : '0;
                        r_ry    <= (i_cmd.action == ACT_POINT) ? r_start_y : '0;
                        r_plen  <= '0;
                        r_rej   <= (i_cmd.action == ACT_APPEND) && !mem_we;
                        r_px    <= r_start_x;
                        r_py    <= r_start_y;
                        r_dist  <= i_cmd.distance;
                        r_total <= '0;
                        r_idx   <= '0;
                        unique case (i_cmd.action)
                            ACT_APPEND: begin
                                r_state <= S_OUT;
                                if (mem_we) begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            ACT_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_OUT;
                            end
                            ACT_POINT: begin
                                if (i_cmd.distance == '0 || r_count == '0) begin
                                    r_state <= S_OUT;
                                end else begin
                                    r_state <= S_RD;
                                end
                            end
                            default: begin
                                if (r_count != '0) begin
                                    r_state <= S_RD;
                                end else begin
                                    r_state <= S_OUT;
                                end
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_LEG;
                end
                S_LEG: begin
                    r_wx    <= r_rdata[63:32];
                    r_wy    <= r_rdata[31:0];
                    r_ax    <= dx[32] ? 32'(-dx) : dx[31:0];
                    r_ay    <= dy[32] ? 32'(-dy) : dy[31:0];
                    r_sx    <= dx[32];
                    r_sy    <= dy[32];
                    r_state <= S_SQX;
                end
                S_SQX: begin
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_sum   <= {1'b0, r_prod};
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_sum   <= r_sum + {1'b0, r_prod};
                    r_state <= S_SQS;
                end
                S_SQS: begin
                    r_state <= S_SQW;
                end
                S_SQW: begin
                    if (sq_done) begin
                        r_len   <= sq_root;
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    if (r_act == ACT_LENGTH) begin
                        r_total <= tot_sat;
                        r_px    <= r_wx;
                        r_py    <= r_wy;
                        r_idx   <= r_idx + CW'(1);
                        if (last_leg) begin
                            r_plen  <= tot_sat;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end else if (DIST_W'(r_len) > r_dist) begin
                        r_axis  <= 1'b0;
                        r_state <= S_MUL;
                    end else begin
                        r_dist <= dist_left;
                        r_px   <= r_wx;
                        r_py   <= r_wy;
                        r_idx  <= r_idx + CW'(1);
                        if (last_leg || dist_left == '0) begin
                            r_rx    <= r_wx;
                            r_ry    <= r_wy;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_MUL: begin
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    r_num   <= {2'b00, r_prod}
                               + (r_dist[32] ? {2'b00, mag, 32'd0} : '0)
                               + NUM_W'(r_len >> 1);
                    r_state <= S_DVS;
                end
                S_DVS: begin
                    r_state <= S_DVW;
                end
                S_DVW: begin
                    if (dv_done) begin
                        if (r_axis) begin
                            r_ry    <= interp;
                            r_state <= S_OUT;
                        end else begin
                            r_rx    <= interp;
                            r_axis  <= 1'b1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || o_res.ready) begin
                        r_ox     <= r_rx;
                        r_oy     <= r_ry;
                        r_olen   <= r_plen;
                        r_orej   <= r_rej;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.result_x    = r_ox;
    assign o_res.result_y    = r_oy;
    assign o_res.path_length = r_olen;
    assign o_res.rejected    = r_orej;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_WAYPOINTS))
        else $error("waypoint count above capacity");

    a_sqrt_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> r_state == S_SQW)
        else $error("square root finished outside its wait state");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_done |-> r_state == S_DVW)
        else $error("division finished outside its wait state");

    a_read_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RD |-> r_idx < r_count)
        else $error("leg read beyond stored waypoints");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the polyline point-at-distance unit: directed and
// random append, clear, point and length commands under random stalls, with
// expected results computed by an in-bench polyline model
// ----------------------------------------------------------------------------
import plpd_pkg::*;

class path_scoreboard;
    localparam int DEPTH = 64;
    logic signed [31:0] way_x[DEPTH];
    logic signed [31:0] way_y[DEPTH];
    int                 way_count;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic [104:0]       pending[$];
    int                 errors;
    int                 checked;

    function new();
        way_count = 0;
        start_x   = 0;
        start_y   = 0;
        errors    = 0;
        checked   = 0;
    endfunction

    function automatic logic [32:0] seg_len(logic signed [63:0] x0, logic signed [63:0] y0,
                                            logic signed [63:0] x1, logic signed [63:0] y1);
        logic [63:0]  ax, ay;
        logic [129:0] sq, p;
        logic [65:0]  lo, hi, m;
        ax = (x1 >= x0) ? x1 - x0 : x0 - x1;
        ay = (y1 >= y0) ? y1 - y0 : y0 - y1;
        sq = 130'(ax) * 130'(ax) + 130'(ay) * 130'(ay);
        lo = 0;
        hi = 66'd1 << 33;
        while (hi - lo > 1) begin
            m = lo + (hi - lo) / 2;
            p = 130'(m) * 130'(m);
            if (p <= sq) lo = m;
            else hi = m;
        end
        p = 130'(lo) * 130'(lo + 1);
        if (sq > p) lo = lo + 1;
        return lo[32:0];
    endfunction

    function automatic logic signed [63:0] lerp(logic signed [63:0] p, logic signed [63:0] q,
                                                logic [39:0] dst, logic [32:0] len);
        logic [63:0]  mag;
        logic [129:0] num;
        logic [63:0]  quo;
        if (len == 0) return p;
        mag = (q >= p) ? q - p : p - q;
        num = 130'(mag) * 130'(dst) + 130'(len >> 1);
        quo = 64'(num / 130'(len));
        return (q >= p) ? p + $signed(quo) : p - $signed(quo);
    endfunction

    function void write_reg(int idx, logic [31:0] val);
        if (idx == 0) start_x = val;
        else if (idx == 1) start_y = val;
    endfunction

    function void note_cmd(t_action act, logic signed [31:0] px, logic signed [31:0] py,
                           t_dist dst);
        logic signed [63:0] cx, cy, rx, ry, wx, wy;
        logic [63:0]        total;
        logic [39:0]        rem, plen;
        logic [32:0]        len;
        logic               rej, found;
        cx = start_x;
        cy = start_y;
        rx = 0;
        ry = 0;
        plen = 0;
        rej = 0;
        case (act)
            ACT_APPEND: begin
                if (way_count >= DEPTH) begin
                    rej = 1;
                end else begin
                    way_x[way_count] = px;
                    way_y[way_count] = py;
                    way_count++;
                end
            end
            ACT_CLEAR: way_count = 0;
            ACT_POINT: begin
                rem = dst;
                found = 0;
                for (int i = 0; i < way_count && rem > 0; i++) begin
                    wx = way_x[i];
                    wy = way_y[i];
                    len = seg_len(cx, cy, wx, wy);
                    if (41'(len) > 41'(rem)) begin
                        rx = lerp(cx, wx, rem, len);
                        ry = lerp(cy, wy, rem, len);
                        found = 1;
                        break;
                    end
                    rem = rem - 40'(len);
                    cx = wx;
                    cy = wy;
                end
                if (!found) begin
                    rx = cx;
                    ry = cy;
                end
            end
            default: begin
                total = 0;
                for (int i = 0; i < way_count; i++) begin
                    wx = way_x[i];
                    wy = way_y[i];
                    total += 64'(seg_len(cx, cy, wx, wy));
                    if (total > 64'hFF_FFFF_FFFF) total = 64'hFF_FFFF_FFFF;
                    cx = wx;
                    cy = wy;
                end
                plen = total[39:0];
            end
        endcase
        pending.push_back({rx[31:0], ry[31:0], plen, rej});
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    task check_res(logic [31:0] rx, logic [31:0] ry, logic [39:0] plen, logic rej);
        logic [104:0] e;
        if (pending.size() == 0) begin
            report("unexpected transaction", '0, '0);
            return;
        end
        e = pending.pop_front();
        checked++;
        if (rx !== e[104:73]) report("result_x", 64'(rx), 64'(e[104:73]));
        if (ry !== e[72:41]) report("result_y", 64'(ry), 64'(e[72:41]));
        if (plen !== e[40:1]) report("path_length", 64'(plen), 64'(e[40:1]));
        if (rej !== e[0]) report("rejected", 64'(rej), 64'(e[0]));
    endtask
endclass

module tb;
    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    bit          calm;
    longint      cycles;
    int          sent;

    plpd_cmd_if cmd_bus ();
    plpd_res_if res_bus ();

    path_scoreboard sb;

    polyline_point_at_distance_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 64'd6_000_000) begin
                $display("timeout");
                $display("tb failed");
                $finish;
            end
        end
    end

    // result side: random stall bursts, checked at the edge
    initial begin
        int gap;
        res_bus.ready = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_bus.valid && res_bus.ready)
                sb.check_res(res_bus.result_x, res_bus.result_y, res_bus.path_length,
                             res_bus.rejected);
            if (!calm && $urandom_range(0, 5) == 0) begin
                res_bus.ready <= 0;
                gap = $urandom_range(1, 17);
                repeat (gap) begin
                    @(posedge i_clk);
                    if (i_rst_n && res_bus.valid && res_bus.ready)
                        sb.check_res(res_bus.result_x, res_bus.result_y,
                                     res_bus.path_length, res_bus.rejected);
                end
                res_bus.ready <= 1;
            end else begin
                res_bus.ready <= 1;
            end
        end
    end

    task cfg_write(int idx, logic [31:0] val);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= 3'(idx * 4);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        sb.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    task send_cmd(t_action act, logic [31:0] px, logic [31:0] py, t_dist dst);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
            cmd_bus.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_bus.valid    <= 1;
        cmd_bus.action   <= act;
        cmd_bus.pos_x    <= px;
        cmd_bus.pos_y    <= py;
        cmd_bus.distance <= dst;
        do @(posedge i_clk); while (!cmd_bus.ready);
        sb.note_cmd(act, px, py, dst);
        sent++;
    endtask

    task drain();
        cmd_bus.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom_range(0, 2000) - 1000;
            1: return $urandom;
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(0, 200000) - 100000;
        endcase
    endfunction

    function automatic t_dist rand_dist();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 40'($urandom_range(1, 3000));
            2: return {8'($urandom), 32'($urandom)};
            3: return 40'hFF_FFFF_FFFF;
            default: return 40'($urandom_range(1, 300000));
        endcase
    endfunction

    initial begin
        int mode, n;
        sb = new();
        calm = 0;
        sent = 0;
        i_rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        cmd_bus.valid = 0;
        cmd_bus.action = ACT_CLEAR;
        cmd_bus.pos_x = 0;
        cmd_bus.pos_y = 0;
        cmd_bus.distance = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty path, extremes, zero legs, overflow
        send_cmd(ACT_POINT, 0, 0, 5);
        send_cmd(ACT_LENGTH, 0, 0, 0);
        send_cmd(ACT_APPEND, 3, 4, 0);
        send_cmd(ACT_APPEND, 3, 4, 0);
        send_cmd(ACT_APPEND, 3, 14, 0);
        send_cmd(ACT_POINT, 0, 0, 0);
        send_cmd(ACT_POINT, 0, 0, 3);
        send_cmd(ACT_POINT, 0, 0, 5);
        send_cmd(ACT_POINT, 0, 0, 10);
        send_cmd(ACT_POINT, 0, 0, 15);
        send_cmd(ACT_POINT, 0, 0, 40'hFF_FFFF_FFFF);
        send_cmd(ACT_LENGTH, 0, 0, 0);
        send_cmd(ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
        drain();
        cfg_write(0, 32'h8000_0000);
        cfg_write(1, 32'h8000_0000);
        for (int i = 0; i < 64; i++)
            send_cmd(ACT_APPEND, (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000,
                     (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000, 0);
        send_cmd(ACT_APPEND, 1, 1, 0);
        send_cmd(ACT_LENGTH, 0, 0, 0);
        send_cmd(ACT_POINT, 0, 0, 40'd6074001000);
        send_cmd(ACT_POINT, 0, 0, 40'h7F_0000_0001);
        send_cmd(ACT_CLEAR, 0, 0, 0);
        drain();
        cfg_write(0, 32'h7FFF_FFFF);
        cfg_write(1, 32'h8000_0000);
        send_cmd(ACT_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_cmd(ACT_POINT, 0, 0, 40'd3037000499);
        send_cmd(ACT_LENGTH, 0, 0, 0);
        send_cmd(ACT_CLEAR, 0, 0, 0);
        drain();

        // random phases: build short paths then query them
        for (int ph = 0; ph < 6; ph++) begin
            mode = ph % 4;
            cfg_write(0, rand_coord(mode));
            cfg_write(1, rand_coord(mode));
            if (ph == 5) calm = 1;
            for (int k = 0; k < 23; k++) begin
                n = $urandom_range(0, 9);
                if (n < 4)
                    send_cmd(ACT_APPEND, rand_coord($urandom_range(0, 1) ? mode : 0),
                             rand_coord($urandom_range(0, 1) ? mode : 0), rand_dist());
                else if (n == 4 && sb.way_count > 6)
                    send_cmd(ACT_CLEAR, $urandom, $urandom, rand_dist());
                else if (n < 8)
                    send_cmd(ACT_POINT, $urandom, $urandom, rand_dist());
                else
                    send_cmd(ACT_LENGTH, $urandom, $urandom, rand_dist());
            end
            drain();
            send_cmd(ACT_CLEAR, 0, 0, 0);
            drain();
        end
        drain();

        $display("sent %0d commands, checked %0d results over several start points", sent,
                 sb.checked);
        $display("covered empty, full and overflowing paths, zero legs and far distances");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule

/* sim.f */
hw/rtl/plpd_pkg.sv
hw/rtl/plpd_if.sv
hw/rtl/plpd_isqrt.sv
hw/rtl/plpd_div.sv
hw/rtl/polyline_point_at_distance_unit.sv
tb/sv/tb.sv
